// File: sv/ifp_pkg.sv
// ----------------------------------------------------------------------------
// ifp_pkg
// shared constants and beat types for the imu frame parser
// ----------------------------------------------------------------------------
package ifp_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'hA7;
  localparam logic [7:0] TYPE_GYRO = 8'h70;
  localparam logic [7:0] TYPE_MAG  = 8'h73;

  localparam int FRAME_LEN = 11;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  localparam int QUEUE_DEPTH = 2;

  // one stored byte of a frame, tagged with its position
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } tok_t;

  // front-end frame tracking state
  typedef struct packed {
    logic             open;
    logic [POS_W-1:0] pos;
  } front_stat_t;

endpackage

// File: sv/ifp_front.sv
// ----------------------------------------------------------------------------
// ifp_front
// takes received bytes, tracks header and position, forwards stored bytes
// ----------------------------------------------------------------------------
module ifp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                queue_full,
  output logic                in_ready,
  output logic                push,
  output ifp_pkg::tok_t       push_tok,
  output ifp_pkg::front_stat_t stat
);
  import ifp_pkg::*;

  logic             open;
  logic             open_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    open_next     = open;
    pos_next      = pos;
    push          = 1'b0;
    push_tok.data = in_byte;
    push_tok.pos  = pos;
    if (accept) begin
      if (in_byte == HDR_BYTE) begin
        // header always restarts, even mid frame
        open_next    = 1'b1;
        pos_next     = '0;
        push         = 1'b1;
        push_tok.pos = '0;
      end else if (open && pos != LAST_POS) begin
        pos_next     = pos + POS_W'(1);
        push         = 1'b1;
        push_tok.pos = pos + POS_W'(1);
        if (pos_next == LAST_POS) begin
          open_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open <= 1'b0;
      pos  <= '0;
    end else begin
      open <= open_next;
      pos  <= pos_next;
    end
  end

  assign stat.open = open;
  assign stat.pos  = pos;

endmodule

// File: sv/ifp_queue.sv
// ----------------------------------------------------------------------------
// ifp_queue
// short fifo of tagged bytes between front and back end
// ----------------------------------------------------------------------------
module ifp_queue #(
  parameter int DEPTH = ifp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ifp_pkg::tok_t push_tok,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output ifp_pkg::tok_t pop_tok
);
  import ifp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_tok   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: sv/ifp_back.sv
// ----------------------------------------------------------------------------
// ifp_back
// stores frame bytes, decodes complete frames into the output register
// ----------------------------------------------------------------------------
module ifp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tok_valid,
  input  ifp_pkg::tok_t        tok,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic signed [15:0]   out_x,
  output logic signed [15:0]   out_y,
  output logic signed [15:0]   out_z
);
  import ifp_pkg::*;

  logic [7:0] frame_bytes [FRAME_LEN];
  logic       last_beat;
  logic       out_free;
  logic       type_ok;

  assign last_beat = (tok.pos == LAST_POS);
  assign out_free  = !out_valid || out_ready;
  // only a completing byte needs room in the output register
  assign pop       = tok_valid && (!last_beat || out_free);
  assign type_ok   = (frame_bytes[2] >= TYPE_GYRO) && (frame_bytes[2] <= TYPE_MAG);

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_bytes[tok.pos] <= tok.data;
    end
    if (pop && last_beat && type_ok) begin
      out_kind <= 2'(frame_bytes[2] - TYPE_GYRO);
      out_x    <= {frame_bytes[6], frame_bytes[5]};
      out_y    <= {frame_bytes[8], frame_bytes[7]};
      out_z    <= {tok.data, frame_bytes[9]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && last_beat && type_ok) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: sv/imu_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_frame_parser
// assembles 11-byte sensor frames from serial bytes, emits decoded axes
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_*      in   tdata[7:0] rx_byte
// m_*      out  tdata[47:0] axis_x, axis_y, axis_z; tuser[1:0] frame_kind
//
// one byte beat per cycle while the queue has room; the front end tracks header and position
// and feeds a small queue, the back end stores bytes and decodes the frame
// m_tvalid rises once the last byte has passed through the queue into the output register
// s_tready drops only when the queue is full, which happens when a finished
// frame waits on m_tready; rst clears position, queue and output valid
// ----------------------------------------------------------------------------
module imu_frame_parser #(
  parameter int QUEUE_DEPTH = ifp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] axis_x, [31:16] axis_y, [47:32] axis_z
  output logic [1:0]  m_tuser    // [1:0] frame_kind
);
  import ifp_pkg::*;

  logic        push;
  tok_t        push_tok;
  tok_t        pop_tok;
  logic        queue_full;
  logic        q_valid;
  logic        q_pop;
  front_stat_t fstat;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;

  ifp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .queue_full (queue_full),
    .in_ready   (s_tready),
    .push       (push),
    .push_tok   (push_tok),
    .stat       (fstat)
  );

  ifp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_tok  (push_tok),
    .pop       (q_pop),
    .full      (queue_full),
    .not_empty (q_valid),
    .pop_tok   (pop_tok)
  );

  ifp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok       (pop_tok),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_x     (axis_x),
    .out_y     (axis_y),
    .out_z     (axis_z)
  );

  assign m_tdata = {axis_z, axis_y, axis_x};

  // a header beat always reopens the frame at position zero
  a_hdr_restart: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata == HDR_BYTE |=> fstat.open && fstat.pos == '0)
    else $error("header beat did not restart the frame");

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    queue_full |-> !push)
    else $error("push into full queue");

  // back end only stalls on a completing byte with the output still occupied
  a_back_stall: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_pop |-> pop_tok.pos == LAST_POS && m_tvalid && !m_tready)
    else $error("back end stalled without cause");

endmodule
